FILE: hdl/tapid_pkg.sv
// Shared constants, types and register codes for the three-axis PID unit.
package tapid_pkg;

    localparam int AXES      = 3;
    localparam int FRAC_BITS = 16;

    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 8;
    localparam int DT_W      = 16;
    localparam int DT_FRAC   = 16;
    localparam int REG_W     = GAIN_W * AXES;
    localparam int NUM_REGS  = 4;
    localparam int IDX_W     = 2;

    localparam int LIM_SHIFT = FRAC_BITS - GAIN_FRAC;
    localparam int INT_W     = GAIN_W + LIM_SHIFT + 1;
    localparam int PROD_W    = DATA_W + GAIN_W + 1;
    localparam int INC_W     = PROD_W - DT_FRAC;
    localparam int SUM_W     = ((INT_W > INC_W) ? INT_W : INC_W) + 1;
    localparam int IPROD_W   = INT_W + GAIN_W + 1;
    localparam int TERM_W    = PROD_W - GAIN_FRAC;
    localparam int ITERM_W   = IPROD_W - GAIN_FRAC;
    localparam int DRV_W     = ((TERM_W > ITERM_W) ? TERM_W : ITERM_W) + 2;

    localparam int S_FIELDS_W = 3 * AXES * DATA_W + DT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((AXES * DATA_W + 7) / 8) * 8;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [GAIN_W-1:0]        gain_t;
    typedef logic [DT_W-1:0]          dt_t;
    typedef logic [REG_W-1:0]         cfg_reg_t;
    typedef logic [AXES-1:0][DATA_W-1:0] drive_vec_t;

    typedef enum logic [IDX_W-1:0] {
        REG_PROP_GAINS   = 2'd0,
        REG_INTEG_GAINS  = 2'd1,
        REG_DERIV_GAINS  = 2'd2,
        REG_INTEG_LIMITS = 2'd3
    } reg_index_t;

    // Per-axis coefficients handed to one lane.
    typedef struct packed {
        gain_t kp;
        gain_t ki;
        gain_t kd;
        gain_t lim;
    } lane_gains_t;

    // Step strobes from the sequencer to every lane.
    typedef struct packed {
        logic load;
        logic mul;
        logic integ;
        logic mul_i;
        logic sum;
    } lane_ctrl_t;

endpackage

FILE: hdl/three_axis_pid_clamped_integral_unit.sv
// Top level of the three-axis PID unit with clamped integrators.
//
//  Channel  Direction  Handshake           Contents
//  s_*      in         s_tvalid/s_tready   feedforward, errors, time step; tuser = clear
//  m_*      out        m_tvalid/m_tready   saturated drive per axis
//  cfg_*    in         cfg_wr_en           gains and integral limits, one per write
//
// An item's result appears on m_* at the hand-over edge. The accepting edge loads
// the lane registers. The sequencer states then take, in order, the three
// products per lane, the integrator update and clamp, the integral product, the
// sum with saturation, and the hand-over to the output register. The sequencer
// holds one item at a time and returns to idle at the hand-over edge, so it takes
// no new item until the last one is handed over. A result left waiting on m_*
// does not block the next item; only the hand-over waits for the output register
// to free up.
// Reset (aresetn low, synchronous) clears the integrators, the gains, the limits
// and the output valid.
module three_axis_pid_clamped_integral_unit
    import tapid_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input item
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // feedforward_x/y/z, prop_error_x/y/z, deriv_error_x/y/z, time_step (from bit 0)
    input  logic [S_TDATA_W-1:0] s_tdata,
    // clear_integral
    input  logic                 s_tuser,
    // Result item
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // drive_x, drive_y, drive_z (from bit 0)
    output logic [M_TDATA_W-1:0] m_tdata,
    // Configuration writes
    input  logic                 cfg_wr_en,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [REG_W-1:0]     cfg_wdata
);

    // One-hot sequencer: each state from ST_MUL to ST_SUM strobes one step in all lanes at once.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_INTEG = 6'b000100,
        ST_MUL_I = 6'b001000,
        ST_SUM   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    cfg_reg_t   prop_gains_reg, integ_gains_reg, deriv_gains_reg, integ_limits_reg;
    lane_ctrl_t ctrl;
    drive_vec_t drives;
    logic       accept;
    logic       out_free;
    logic       out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && out_free;

    // Configuration registers; the user writes them only while idle, not enforced here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gains_reg   <= '0;
            integ_gains_reg  <= '0;
            deriv_gains_reg  <= '0;
            integ_limits_reg <= '0;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_index))
                REG_PROP_GAINS:   prop_gains_reg   <= cfg_wdata;
                REG_INTEG_GAINS:  integ_gains_reg  <= cfg_wdata;
                REG_DERIV_GAINS:  deriv_gains_reg  <= cfg_wdata;
                REG_INTEG_LIMITS: integ_limits_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_MUL;
            ST_MUL:   state_next = ST_INTEG;
            ST_INTEG: state_next = ST_MUL_I;
            ST_MUL_I: state_next = ST_SUM;
            ST_SUM:   state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        ctrl.load  = accept;
        ctrl.mul   = (state_reg == ST_MUL);
        ctrl.integ = (state_reg == ST_INTEG);
        ctrl.mul_i = (state_reg == ST_MUL_I);
        ctrl.sum   = (state_reg == ST_SUM);
    end

    // One lane per axis; the time step and the clear flag are common to all.
    for (genvar a = 0; a < AXES; a++) begin : g_lane
        lane_gains_t gains;
        data_t       drive;

        assign gains.kp  = prop_gains_reg[a*GAIN_W +: GAIN_W];
        assign gains.ki  = integ_gains_reg[a*GAIN_W +: GAIN_W];
        assign gains.kd  = deriv_gains_reg[a*GAIN_W +: GAIN_W];
        assign gains.lim = integ_limits_reg[a*GAIN_W +: GAIN_W];

        tapid_lane u_lane (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .ctrl           (ctrl),
            .gains          (gains),
            .feedforward    (data_t'(s_tdata[a*DATA_W +: DATA_W])),
            .prop_error     (data_t'(s_tdata[(AXES+a)*DATA_W +: DATA_W])),
            .deriv_error    (data_t'(s_tdata[(2*AXES+a)*DATA_W +: DATA_W])),
            .time_step      (s_tdata[3*AXES*DATA_W +: DT_W]),
            .clear_integral (s_tuser),
            .drive          (drive)
        );

        assign drives[a] = drive;
    end

    tapid_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .drives   (drives),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .out_free (out_free)
    );

endmodule

FILE: hdl/tapid_lane.sv
// One axis of the controller: products, clamped integrator and saturated sum.
module tapid_lane
    import tapid_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  lane_ctrl_t  ctrl,
    input  lane_gains_t gains,
    input  data_t       feedforward,
    input  data_t       prop_error,
    input  data_t       deriv_error,
    input  dt_t         time_step,
    input  logic        clear_integral,
    output data_t       drive
);

    data_t ff_reg, ep_reg, ed_reg;
    dt_t   dt_reg;
    logic  clr_reg;

    logic signed [PROD_W-1:0]  inc_prod_reg, p_prod_reg, d_prod_reg;
    logic signed [IPROD_W-1:0] i_prod_reg;
    logic signed [INT_W-1:0]   integ_reg, integ_next;
    data_t                     drive_reg;

    logic signed [INT_W-1:0] integ_base;
    logic signed [INC_W-1:0] inc;
    logic signed [SUM_W-1:0] sum, lim_pos, lim_neg;
    logic signed [DRV_W-1:0] total;
    logic signed [DRV_W-1:0] sat_max, sat_min;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            ff_reg  <= feedforward;
            ep_reg  <= prop_error;
            ed_reg  <= deriv_error;
            dt_reg  <= time_step;
            clr_reg <= clear_integral;
        end
        if (ctrl.mul) begin
            inc_prod_reg <= PROD_W'(ep_reg * $signed({1'b0, dt_reg}));
            p_prod_reg   <= PROD_W'(ep_reg * $signed({1'b0, gains.kp}));
            d_prod_reg   <= PROD_W'(ed_reg * $signed({1'b0, gains.kd}));
        end
        if (ctrl.mul_i) begin
            i_prod_reg <= IPROD_W'(integ_reg * $signed({1'b0, gains.ki}));
        end
        if (ctrl.sum) begin
            drive_reg <= (total > sat_max) ? data_t'(sat_max[DATA_W-1:0]) :
                         (total < sat_min) ? data_t'(sat_min[DATA_W-1:0]) :
                         data_t'(total[DATA_W-1:0]);
        end
    end

    // Integrator update: optional clear, floor of the scaled increment, then clamp to +/- the limit.
    always_comb begin
        integ_base = clr_reg ? '0 : integ_reg;
        inc        = $signed(inc_prod_reg[PROD_W-1:DT_FRAC]);
        sum        = SUM_W'(integ_base) + SUM_W'(inc);
        lim_pos    = $signed(SUM_W'({gains.lim, {LIM_SHIFT{1'b0}}}));
        lim_neg    = -lim_pos;
        if (sum > lim_pos) begin
            integ_next = lim_pos[INT_W-1:0];
        end else if (sum < lim_neg) begin
            integ_next = lim_neg[INT_W-1:0];
        end else begin
            integ_next = sum[INT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
        end else if (ctrl.integ) begin
            integ_reg <= integ_next;
        end
    end

    always_comb begin
        total = DRV_W'(ff_reg)
              + DRV_W'($signed(p_prod_reg[PROD_W-1:GAIN_FRAC]))
              + DRV_W'($signed(d_prod_reg[PROD_W-1:GAIN_FRAC]))
              + DRV_W'($signed(i_prod_reg[IPROD_W-1:GAIN_FRAC]));
        sat_max = DRV_W'({1'b0, {(DATA_W-1){1'b1}}});
        sat_min = -sat_max - DRV_W'(1);
    end

    assign drive = drive_reg;

endmodule

FILE: hdl/tapid_merge.sv
// Output stage: gathers the lane results into one item and holds it for the sink.
module tapid_merge
    import tapid_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  drive_vec_t           drives,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 out_free
);

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= M_TDATA_W'(drives);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: hdl/tapid_checker.sv
// Port-level checks on the PID unit, bound to its top level.
module tapid_checker
    import tapid_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A waiting result holds its data.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("waiting result changed");

    // The sequencer takes no new item during the five steps of one item.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready
                                 ##1 !s_tready ##1 !s_tready)
        else $error("item accepted while another is in progress");

    // A result is only loaded from the final step, never from idle.
    a_load_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an item in progress");

endmodule

bind three_axis_pid_clamped_integral_unit tapid_checker u_tapid_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: test/three_axis_pid_clamped_integral_unit_tb.sv
// Self-checking testbench for the three-axis PID unit with clamped integrators.
module three_axis_pid_clamped_integral_unit_tb;
    import tapid_pkg::*;

    // One value per axis, x in the lowest 32 bits.
    typedef logic [AXES-1:0][DATA_W-1:0] axis_vec_t;

    // One input item as the unit sees it on s_tdata and s_tuser.
    typedef struct packed {
        logic      clr;
        dt_t       dt;
        axis_vec_t ed;
        axis_vec_t ep;
        axis_vec_t ff;
    } pid_item_t;

    // A row of the directed table. When fixed is set, the drive that the row
    // must produce is typed in; otherwise it comes from the predictor. gains_set
    // picks the register set that must be loaded before the row is offered.
    typedef struct packed {
        logic [1:0] gains_set;
        logic       fixed;
        axis_vec_t  want;
        pid_item_t  it;
    } dir_row_t;

    localparam logic [DATA_W-1:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] MINV = 32'h8000_0000;
    localparam dt_t               DT_MAX = 16'hFFFF;
    localparam cfg_reg_t          REG_ONES = 48'hFFFF_FFFF_FFFF;
    localparam longint            DRIVE_MAX = 64'sd2147483647;
    localparam longint            DRIVE_MIN = -64'sd2147483648;

    // Settling margin before any register write or the final verdict.
    localparam int SETTLE_CYCLES     = 8;
    localparam int SINK_HOLD_CYCLES  = 60;
    localparam int RAND_PHASES       = 12;
    localparam int ITEMS_PER_PHASE   = 120;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [REG_W-1:0]     cfg_wdata = '0;

    // Predictor copy of the registers and of the three integrators.
    cfg_reg_t prop_r  = '0;
    cfg_reg_t integ_r = '0;
    cfg_reg_t deriv_r = '0;
    cfg_reg_t lim_r   = '0;
    longint   integ_acc [AXES];

    // Drives still owed by the unit, oldest first.
    axis_vec_t drive_q [$];
    int        mismatches = 0;

    // Pacing controls shared by the sender and the receiver. idle_off gives a
    // stretch with no gaps on either side; sink_hold asks the receiver for one
    // long hold-off, which it counts out itself and then clears.
    bit idle_off  = 1'b0;
    bit sink_hold = 1'b0;

    dir_row_t dir_tab [$];
    cfg_reg_t set_kp  [4];
    cfg_reg_t set_ki  [4];
    cfg_reg_t set_kd  [4];
    cfg_reg_t set_lim [4];

    three_axis_pid_clamped_integral_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // The predictor. The clear flag zeroes every integrator first; each axis
    // then adds floor(e_prop * dt / 2^16), clamps to +/- (limit << 8) and
    // forms ff + floor(Kp*e_prop/256) + floor(Kd*e_deriv/256) +
    // floor(Ki*integral/256), saturated to 32 bits. All of it fits in 64-bit
    // signed arithmetic, where >>> rounds towards minus infinity.
    function automatic axis_vec_t pid_update(input pid_item_t it);
        axis_vec_t drive;
        longint    ff, ep, ed, dtv, lim, acc, total, kp, ki, kd;
        int        a;
        if (it.clr) begin
            for (a = 0; a < AXES; a++) integ_acc[a] = 0;
        end
        dtv = it.dt;
        for (a = 0; a < AXES; a++) begin
            ff  = data_t'(it.ff[a]);
            ep  = data_t'(it.ep[a]);
            ed  = data_t'(it.ed[a]);
            kp  = prop_r[GAIN_W*a +: GAIN_W];
            ki  = integ_r[GAIN_W*a +: GAIN_W];
            kd  = deriv_r[GAIN_W*a +: GAIN_W];
            lim = lim_r[GAIN_W*a +: GAIN_W];
            lim = lim <<< LIM_SHIFT;
            acc = integ_acc[a] + ((ep * dtv) >>> DT_FRAC);
            if (acc > lim) acc = lim;
            if (acc < -lim) acc = -lim;
            integ_acc[a] = acc;
            total = ff + ((ep * kp) >>> GAIN_FRAC) + ((ed * kd) >>> GAIN_FRAC)
                  + ((acc * ki) >>> GAIN_FRAC);
            if (total > DRIVE_MAX) total = DRIVE_MAX;
            if (total < DRIVE_MIN) total = DRIVE_MIN;
            drive[a] = total[DATA_W-1:0];
        end
        return drive;
    endfunction

    function automatic dir_row_t mk_row(input int sel, input bit fixed, input axis_vec_t want,
                                        input axis_vec_t ff, input axis_vec_t ep,
                                        input axis_vec_t ed, input dt_t dt, input bit clr);
        dir_row_t r;
        r.gains_set = sel[1:0];
        r.fixed     = fixed;
        r.want      = want;
        r.it.ff     = ff;
        r.it.ep     = ep;
        r.it.ed     = ed;
        r.it.dt     = dt;
        r.it.clr    = clr;
        return r;
    endfunction

    // Q16.16 values: a share of the extremes, a share of small values around
    // zero (so that integrators build up before they clamp), the rest uniform.
    function automatic logic [DATA_W-1:0] pick_q16();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = MAXV;
            1: v = MINV;
            2: v = '0;
            3: v = 32'hFFFF_FFFF;
            4, 5, 6: v = $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Q8.8 gain or limit word, biased towards the useful range up to 4.0.
    function automatic gain_t pick_word();
        gain_t w;
        case ($urandom_range(0, 7))
            0: w = '0;
            1: w = '1;
            2, 3, 4: w = $urandom_range(0, 16'h0400);
            default: w = $urandom_range(0, 16'hFFFF);
        endcase
        return w;
    endfunction

    function automatic pid_item_t pick_item();
        pid_item_t it;
        int        a;
        for (a = 0; a < AXES; a++) begin
            it.ff[a] = pick_q16();
            it.ep[a] = pick_q16();
            it.ed[a] = pick_q16();
        end
        case ($urandom_range(0, 7))
            0: it.dt = '0;
            1: it.dt = DT_MAX;
            default: it.dt = $urandom_range(0, 16'hFFFF);
        endcase
        it.clr = ($urandom_range(0, 11) == 0);
        return it;
    endfunction

    // Offers one item and returns at the rising edge that accepts it. The
    // valid is left high after acceptance: the next call decides at the
    // following falling edge whether it drops for a gap or carries on, so the
    // valid never sees two assignments in one time step.
    task automatic offer_item(input pid_item_t it);
        int pause;
        pause = (idle_off || sink_hold) ? 0 : $urandom_range(0, 4);
        @(negedge aclk);
        if (pause != 0) begin
            s_tvalid <= 1'b0;
            repeat (pause) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.dt, it.ed, it.ep, it.ff};
        s_tuser  <= it.clr;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    // Stops offering, waits until every owed drive has come back, then lets
    // the pipeline settle.
    task automatic quiesce();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (drive_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Writes all four registers on consecutive cycles; only called while idle.
    task automatic load_gains(input cfg_reg_t kp, input cfg_reg_t ki, input cfg_reg_t kd,
                              input cfg_reg_t lim);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_PROP_GAINS;
        cfg_wdata <= kp;
        @(negedge aclk);
        cfg_index <= REG_INTEG_GAINS;
        cfg_wdata <= ki;
        @(negedge aclk);
        cfg_index <= REG_DERIV_GAINS;
        cfg_wdata <= kd;
        @(negedge aclk);
        cfg_index <= REG_INTEG_LIMITS;
        cfg_wdata <= lim;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        prop_r  = kp;
        integ_r = ki;
        deriv_r = kd;
        lim_r   = lim;
    endtask

    // Compares one accepted result with the oldest owed drive, axis by axis.
    task automatic check_drive(input axis_vec_t got);
        axis_vec_t want;
        int        a;
        if (drive_q.size() == 0) begin
            $display("%0t: drive %h arrived with no item outstanding", $time, got);
            mismatches++;
        end else begin
            want = drive_q.pop_front();
            for (a = 0; a < AXES; a++) begin
                if (got[a] !== want[a]) begin
                    $display("%0t: drive axis %0d expected %h got %h",
                             $time, a, want[a], got[a]);
                    mismatches++;
                end
            end
        end
    endtask

    // Receiver. Each result waits a random pause for m_tready, except in the
    // no-idle stretches, and once it is held off for a long stretch so that
    // the output register fills and the unit stops taking input.
    initial begin : sink
        int pause;
        forever begin
            pause = idle_off ? 0 : $urandom_range(0, 4);
            @(negedge aclk);
            if (sink_hold) begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(negedge aclk);
                sink_hold = 1'b0;
            end else if (pause != 0) begin
                m_tready <= 1'b0;
                repeat (pause) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            check_drive(m_tdata[AXES*DATA_W-1:0]);
        end
    end

    // Hard stop. The slowest correct run is about 1460 items plus the register
    // phases and the long hold-off, some 42000 time units; this allows nearly
    // ten times that.
    initial begin : watchdog
        #400000;
        $display("[three_axis_pid_clamped_integral_unit] ERROR");
        $finish;
    end

    initial begin : stimulus
        dir_row_t  row;
        pid_item_t it;
        axis_vec_t want;
        int        cur_set;
        int        p, n, a;

        for (a = 0; a < AXES; a++) integ_acc[a] = 0;

        // Register sets for the directed part. Set 0 is the reset state and is
        // never written. Set 1 puts every gain and limit at its maximum. Set 2
        // has only an integral gain of 1.0 and a limit of 2.0, so that the
        // integrator can be watched walking up into its clamp. Set 3 has a zero
        // limit, which must pin every integrator at zero, and distinct proportional
        // and derivative gains per axis to show up any mix-up of the packed words.
        set_kp[0] = '0;       set_ki[0] = '0;       set_kd[0] = '0;       set_lim[0] = '0;
        set_kp[1] = REG_ONES; set_ki[1] = REG_ONES; set_kd[1] = REG_ONES; set_lim[1] = REG_ONES;
        set_kp[2] = '0;       set_kd[2] = '0;
        set_ki[2]  = {3{16'h0100}};
        set_lim[2] = {3{16'h0200}};
        set_kp[3]  = 48'h0080_0100_0040;
        set_ki[3]  = REG_ONES;
        set_kd[3]  = 48'h0200_0001_0010;
        set_lim[3] = '0;

        // With reset gains the drive is the feedforward alone, at the extremes
        // too, and the clear flag changes nothing visible.
        dir_tab.push_back(mk_row(0, 1, '0, '0, '0, '0, '0, 1'b0));
        dir_tab.push_back(mk_row(0, 1, {3{MAXV}}, {3{MAXV}}, {3{MAXV}}, {3{MAXV}}, DT_MAX, 1'b0));
        dir_tab.push_back(mk_row(0, 1, {3{MINV}}, {3{MINV}}, {3{MINV}}, {3{MINV}}, DT_MAX, 1'b1));
        dir_tab.push_back(mk_row(0, 1, {32'd0, 32'hFFFF_FFFF, 32'd1},
                                 {32'd0, 32'hFFFF_FFFF, 32'd1},
                                 {32'd3, 32'd2, 32'd1}, '0, 16'd1, 1'b0));
        // Full gains: both saturation limits, then a clear with all else zero.
        dir_tab.push_back(mk_row(1, 1, {3{MAXV}}, {3{MAXV}}, {3{MAXV}}, {3{MAXV}}, DT_MAX, 1'b0));
        dir_tab.push_back(mk_row(1, 1, {3{MINV}}, {3{MINV}}, {3{MINV}}, {3{MINV}}, DT_MAX, 1'b0));
        dir_tab.push_back(mk_row(1, 1, '0, '0, '0, '0, '0, 1'b1));
        // Small values of both signs, where rounding towards minus infinity shows.
        dir_tab.push_back(mk_row(1, 0, '0, '0, {32'hFFFF_FF00, 32'h0000_0100, 32'h0000_0001},
                                 {32'd0, 32'd1, 32'hFFFF_FFFF}, 16'h8000, 1'b0));
        dir_tab.push_back(mk_row(1, 0, '0, {3{32'd5}}, {3{32'hFFFF_FFFF}},
                                 {3{32'hFFFF_FFFF}}, 16'd1, 1'b0));
        // Integrator walk: +0.5 per item up to the +2.0 clamp and beyond it,
        // then nearly -3.0 per item down into the negative clamp, then a clear.
        dir_tab.push_back(mk_row(2, 0, '0, '0, {3{32'h0001_0000}}, '0, 16'h8000, 1'b1));
        repeat (4) dir_tab.push_back(mk_row(2, 0, '0, '0, {3{32'h0001_0000}}, '0,
                                            16'h8000, 1'b0));
        repeat (3) dir_tab.push_back(mk_row(2, 0, '0, {32'd7, 32'd0, 32'hFFFF_FFF9},
                                            {3{32'hFFFD_0000}}, '0, DT_MAX, 1'b0));
        dir_tab.push_back(mk_row(2, 1, '0, '0, '0, '0, '0, 1'b1));
        // Zero limit: the integral term must vanish whatever the error.
        dir_tab.push_back(mk_row(3, 0, '0, '0, {3{MAXV}}, {3{MINV}}, DT_MAX, 1'b0));
        dir_tab.push_back(mk_row(3, 0, '0, {32'd3, 32'd2, 32'd1}, {3{MINV}}, {3{MAXV}},
                                 DT_MAX, 1'b0));
        dir_tab.push_back(mk_row(3, 0, '0, {3{MAXV}}, {3{32'h0001_0000}}, '0, 16'h1234, 1'b0));

        // Synchronous reset, released at a falling edge.
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        cur_set = 0;
        foreach (dir_tab[n]) begin
            row = dir_tab[n];
            if (int'(row.gains_set) != cur_set) begin
                quiesce();
                cur_set = row.gains_set;
                load_gains(set_kp[cur_set], set_ki[cur_set], set_kd[cur_set],
                           set_lim[cur_set]);
            end
            offer_item(row.it);
            want = pid_update(row.it);
            drive_q.push_back(row.fixed ? row.want : want);
        end

        // Random phases, each under its own register setting: all ones, all
        // zeros, then random words per axis. One phase in four runs with no
        // idling on either side; one phase includes the long receiver hold-off
        // and another a pause of the sender until everything has drained.
        for (p = 0; p < RAND_PHASES; p++) begin
            quiesce();
            if (p == 0) begin
                load_gains(REG_ONES, REG_ONES, REG_ONES, REG_ONES);
            end else if (p == 1) begin
                load_gains('0, '0, '0, '0);
            end else begin
                load_gains({pick_word(), pick_word(), pick_word()},
                           {pick_word(), pick_word(), pick_word()},
                           {pick_word(), pick_word(), pick_word()},
                           {pick_word(), pick_word(), pick_word()});
            end
            idle_off = (p % 4 == 2);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 3 && n == 10) sink_hold = 1'b1;
                if (p == 5 && n == 50) quiesce();
                it = pick_item();
                offer_item(it);
                drive_q.push_back(pid_update(it));
            end
        end
        idle_off = 1'b0;

        // Drain, give any stray result time to show up, then decide.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (drive_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES * 2) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[three_axis_pid_clamped_integral_unit] OK");
        end else begin
            $display("[three_axis_pid_clamped_integral_unit] ERROR");
        end
        $finish;
    end

endmodule

FILE: three_axis_pid_clamped_integral_unit.f
hdl/tapid_pkg.sv
hdl/tapid_lane.sv
hdl/tapid_merge.sv
hdl/three_axis_pid_clamped_integral_unit.sv
hdl/tapid_checker.sv
test/three_axis_pid_clamped_integral_unit_tb.sv
